/* design/blri_pkg.sv */
// shared types and constants of the bounded lcg random integer block
// no dependencies; imported by the result interface, the top level and the checker
package blri_pkg;

	localparam int unsigned STATE_W = 64;
	localparam int unsigned SEED_W  = 32;
	localparam int unsigned OUT_SHIFT = 33;
	localparam int unsigned DRAW_W  = STATE_W - OUT_SHIFT;   // 31-bit drawn value
	localparam int unsigned DIGIT_W = 2;
	localparam int unsigned MUL_STEPS = STATE_W / DIGIT_W;   // radix-4 digits
	localparam int unsigned CNT_W   = 5;

	localparam logic [STATE_W-1:0] LCG_MULT = 64'd6364136223846793005;
	localparam logic [STATE_W-1:0] LCG_INC  = 64'd1442695040888963407;
	localparam logic [STATE_W-1:0] LCG_MULT2 = STATE_W'(LCG_MULT << 1);
	localparam logic [STATE_W-1:0] LCG_MULT3 = STATE_W'(LCG_MULT + LCG_MULT2);

	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DRAW_W - 1);

	localparam logic [SEED_W-1:0]  SEED_RST = '0;
	localparam logic [STATE_W-1:0] LOW_RST  = '0;
	localparam logic [STATE_W-1:0] HIGH_RST = 64'd1;

	typedef logic signed [STATE_W-1:0] value_t;

	typedef enum logic [1:0] {
		CFG_SEED = 2'd0,
		CFG_LOW  = 2'd1,
		CFG_HIGH = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_INC,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

/* design/blri_if.sv */
// valid/ready channel interfaces for the request and result transactions
// depends on blri_pkg for the result value type
interface blri_req_if;
	logic valid;
	logic ready;
	logic start_run;

	modport source (output valid, output start_run, input ready);
	modport sink (input valid, input start_run, output ready);
endinterface

interface blri_rsp_if
	import blri_pkg::*;
;
	logic   valid;
	logic   ready;
	value_t random_value;
	logic   range_error;

	modport source (output valid, output random_value, output range_error, input ready);
	modport sink (input valid, input random_value, input range_error, output ready);
endinterface

/* design/bounded_lcg_random_integers.sv */
// bounded random integers: 64-bit lcg stepped by a radix-4 serial multiplier,
// then a bit-serial restoring modulo of the drawn 31-bit value by the range
// a request transaction runs 32 multiply digits (ST_MUL), 1 increment add (ST_INC),
// 31 modulo bits (ST_DIV) and then the output register load (ST_DONE)
// a new request is taken only after the previous result is loaded into the output register
// reset: arst_n clears control, output valid and the lcg state; registers take 0, 0, 1
module bounded_lcg_random_integers
	import blri_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [STATE_W-1:0]  cfg_data,
	blri_req_if.sink            req,
	blri_rsp_if.source          rsp
);

	// configuration registers
	logic [SEED_W-1:0]  seed_q;
	logic [STATE_W-1:0] low_q;
	logic [STATE_W-1:0] high_q;

	// sequencer
	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	// datapath
	logic [STATE_W-1:0] gen_q;      // lcg state between transactions
	logic [STATE_W-1:0] mplier_q;   // multiplier shift register, msb digit first
	logic [STATE_W-1:0] prod_q;     // horner accumulator of state * multiplier
	logic [STATE_W-1:0] span_q;     // high minus low, unsigned wrap
	logic               zero_q;     // span is zero
	logic [DRAW_W-1:0]  div_q;      // dividend shift register, msb first
	logic [DRAW_W:0]    rem_q;      // partial remainder

	// output register
	logic               out_vld_q;
	value_t             out_val_q;
	logic               out_err_q;

	logic               accept;
	logic               load_out;
	logic [STATE_W-1:0] digit_mult;
	logic [STATE_W-1:0] next_gen;
	logic [DRAW_W:0]    trial;
	logic               trial_ge;
	logic [STATE_W-1:0] span_d;

	// configuration writes, index three is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RST;
			low_q  <= LOW_RST;
			high_q <= HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SEED: seed_q <= cfg_data[SEED_W-1:0];
				CFG_LOW:  low_q  <= cfg_data;
				CFG_HIGH: high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (req.valid) state_d = ST_MUL;
			ST_MUL:  if (cnt_q == MUL_LAST) state_d = ST_INC;
			ST_INC:  state_d = ST_DIV;
			ST_DIV:  if (cnt_q == DIV_LAST) state_d = ST_DONE;
			ST_DONE: if (!out_vld_q || rsp.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake outputs of the sequencer
	always_comb begin
		req.ready = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_DONE: load_out  = !out_vld_q || rsp.ready;
			default: ;
		endcase
	end

	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// radix-4 digit of the state picks a multiple of the constant multiplier
	always_comb begin
		case (mplier_q[STATE_W-1 -: DIGIT_W])
			2'd1:    digit_mult = LCG_MULT;
			2'd2:    digit_mult = LCG_MULT2;
			2'd3:    digit_mult = LCG_MULT3;
			default: digit_mult = '0;
		endcase
	end

	assign next_gen = prod_q + LCG_INC;
	assign span_d   = high_q - low_q;

	// restoring modulo step: shift in the next dividend bit, subtract when it fits
	assign trial    = {rem_q[DRAW_W-1:0], div_q[DRAW_W-1]};
	assign trial_ge = {{(STATE_W-DRAW_W-1){1'b0}}, trial} >= span_q;

	// the lcg state is architectural and reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= '0;
		end else if (state_q == ST_INC) begin
			gen_q <= next_gen;
		end
	end

	// serial datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			// a run start reloads the state from the seed
			mplier_q <= req.start_run ? {{(STATE_W-SEED_W){1'b0}}, seed_q} : gen_q;
			prod_q   <= '0;
			span_q   <= span_d;
			zero_q   <= (span_d == '0);
		end else if (state_q == ST_MUL) begin
			prod_q   <= {prod_q[STATE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + digit_mult;
			mplier_q <= {mplier_q[STATE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
		if (state_q == ST_INC) begin
			div_q <= next_gen[STATE_W-1:OUT_SHIFT];
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			div_q <= {div_q[DRAW_W-2:0], 1'b0};
			rem_q <= trial_ge ? trial - span_q[DRAW_W:0] : trial;
		end
	end

	// output register parts the result transaction from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			// a zero range gives low and raises the error flag
			out_val_q <= zero_q ? value_t'(low_q)
				: value_t'(low_q + {{(STATE_W-DRAW_W-1){1'b0}}, rem_q});
			out_err_q <= zero_q;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.random_value = out_val_q;
	assign rsp.range_error  = out_err_q;

endmodule

/* design/blri_checker.sv */
// port-level checks of the bounded lcg random integer block, bound to its top level
// depends on blri_pkg and on the top level's ports
module blri_checker
	import blri_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	input logic   req_valid,
	input logic   req_ready,
	input logic   rsp_valid,
	input logic   rsp_ready,
	input value_t rsp_value,
	input logic   rsp_error
);

	// a pending result stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped before transaction");

	// a pending result keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_value) && $stable(rsp_error))
		else $error("result payload changed while stalled");

	// one item at a time: busy right after a request transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// no result can appear right after a request transaction
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("result appeared too early");

endmodule

bind bounded_lcg_random_integers blri_checker u_blri_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_value (rsp.random_value),
	.rsp_error (rsp.range_error)
);
